[rtl/ocs_pkg.sv]
// Package for the opponent color saliency block: widths, register indexes,
// reset values, pipeline depth and the per-category lane record.
// No dependencies; every other file imports it.
package ocs_pkg;

    localparam int PIX_W       = 8;
    localparam int NUM_CAT     = 5;
    localparam int FULL_SCALE  = 255;

    // category bit positions in category_enable
    localparam int CAT_RED     = 0;
    localparam int CAT_GREEN   = 1;
    localparam int CAT_CYAN    = 2;
    localparam int CAT_PURPLE  = 3;
    localparam int CAT_YELLOW  = 4;

    // divider: quotient bits retired per stage and stage count
    localparam int DIV_STEPS   = 2;
    localparam int DIV_STAGES  = PIX_W / DIV_STEPS;

    // prep stage + divider stages + max/output stage
    localparam int NUM_STAGES  = DIV_STAGES + 2;
    localparam int FLIGHT_W    = $clog2(NUM_STAGES + 1);

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAT_ENABLE     = 2'd0,
        REG_DIFF_THRESHOLD = 2'd1,
        REG_LEVEL_FLOOR    = 2'd2
    } reg_index_t;

    localparam logic [NUM_CAT-1:0] RST_CAT_ENABLE     = 5'd1;
    localparam logic [PIX_W-1:0]   RST_DIFF_THRESHOLD = 8'd15;
    localparam logic [PIX_W-1:0]   RST_LEVEL_FLOOR    = 8'd40;

    typedef struct packed {
        logic [NUM_CAT-1:0] cat_enable;
        logic [PIX_W-1:0]   diff_threshold;
        logic [PIX_W-1:0]   level_floor;
    } cfg_t;

    // One category in flight through the divider. quot starts as the low
    // byte of the dividend and fills with quotient bits from the bottom.
    typedef struct packed {
        logic             pass;
        logic [PIX_W-1:0] level;
        logic [PIX_W-1:0] rem;
        logic [PIX_W-1:0] quot;
    } lane_t;

endpackage

[rtl/ocs_if.sv]
// Stream and configuration interfaces of the opponent color saliency block.
// Depends on ocs_pkg for widths.

interface ocs_pixel_if
    import ocs_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;

    modport source (output valid, output blue, output green, output red, input ready);
    modport sink   (input valid, input blue, input green, input red, output ready);
endinterface

interface ocs_result_if
    import ocs_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] saliency;

    modport source (output valid, output saliency, input ready);
    modport sink   (input valid, input saliency, output ready);
endinterface

interface ocs_cfg_if
    import ocs_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/ocs_prep.sv]
// First pipeline stage: opponent levels, rivals, qualification tests and
// the dividend diff*255 for all five categories. Depends on ocs_pkg.
module ocs_prep
    import ocs_pkg::*;
(
    input  logic                     clk,
    input  logic                     load,
    input  logic [PIX_W-1:0]         blue,
    input  logic [PIX_W-1:0]         green,
    input  logic [PIX_W-1:0]         red,
    input  cfg_t                     cfg,
    output lane_t [NUM_CAT-1:0]      lanes
);

    logic [PIX_W-1:0]      level [NUM_CAT];
    logic [PIX_W-1:0]      rival [NUM_CAT];
    lane_t [NUM_CAT-1:0]   lanes_next;
    lane_t [NUM_CAT-1:0]   lanes_reg;

    function automatic logic [PIX_W-1:0] max2(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic [PIX_W-1:0] min2(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    // target and rival level per category
    always_comb
    begin
        level[CAT_RED]    = red;
        rival[CAT_RED]    = max2(green, blue);
        level[CAT_GREEN]  = green;
        rival[CAT_GREEN]  = max2(red, blue);
        level[CAT_CYAN]   = min2(green, blue);
        rival[CAT_CYAN]   = red;
        level[CAT_PURPLE] = min2(red, blue);
        rival[CAT_PURPLE] = green;
        level[CAT_YELLOW] = min2(red, green);
        rival[CAT_YELLOW] = blue;
    end

    // tests and dividend; diff*255 = (diff << 8) - diff
    always_comb
    begin
        logic [PIX_W-1:0]   diff;
        logic [2*PIX_W-1:0] dividend;
        for (int i = 0; i < NUM_CAT; i++)
        begin
            diff     = level[i] - rival[i];
            dividend = {diff, {PIX_W{1'b0}}} - {{PIX_W{1'b0}}, diff};
            lanes_next[i].pass  = cfg.cat_enable[i]
                                  && (level[i] > rival[i])
                                  && (diff > cfg.diff_threshold)
                                  && (level[i] > cfg.level_floor);
            lanes_next[i].level = level[i];
            // upper byte is below level whenever diff < level
            lanes_next[i].rem   = dividend[2*PIX_W-1:PIX_W];
            lanes_next[i].quot  = dividend[PIX_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            lanes_reg <= lanes_next;
        end
    end

    assign lanes = lanes_reg;

endmodule

[rtl/ocs_div_stage.sv]
// One divider stage: DIV_STEPS restoring division steps on every lane,
// then a register. Depends on ocs_pkg.
module ocs_div_stage
    import ocs_pkg::*;
(
    input  logic                 clk,
    input  logic                 load,
    input  lane_t [NUM_CAT-1:0]  din,
    output lane_t [NUM_CAT-1:0]  dout
);

    lane_t [NUM_CAT-1:0] dout_next;
    lane_t [NUM_CAT-1:0] dout_reg;

    // shift in the next dividend bit, subtract level when it fits
    always_comb
    begin
        logic [PIX_W:0] trial;
        logic           fits;
        lane_t          cur;
        for (int i = 0; i < NUM_CAT; i++)
        begin
            cur = din[i];
            for (int s = 0; s < DIV_STEPS; s++)
            begin
                trial    = {cur.rem, cur.quot[PIX_W-1]};
                fits     = (trial >= {1'b0, cur.level});
                cur.rem  = fits ? PIX_W'(trial - {1'b0, cur.level}) : trial[PIX_W-1:0];
                cur.quot = {cur.quot[PIX_W-2:0], fits};
            end
            dout_next[i] = cur;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

[rtl/ocs_max.sv]
// Last stage: largest quotient among qualified lanes, registered as the
// output saliency. Depends on ocs_pkg.
module ocs_max
    import ocs_pkg::*;
(
    input  logic                 clk,
    input  logic                 load,
    input  lane_t [NUM_CAT-1:0]  lanes,
    output logic [PIX_W-1:0]     saliency
);

    logic [PIX_W-1:0] best_next;
    logic [PIX_W-1:0] best_reg;

    // disqualified lanes count as zero; quotient never exceeds 255
    always_comb
    begin
        best_next = '0;
        for (int i = 0; i < NUM_CAT; i++)
        begin
            if (lanes[i].pass && (lanes[i].quot > best_next))
            begin
                best_next = lanes[i].quot;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            best_reg <= best_next;
        end
    end

    assign saliency = best_reg;

endmodule

[rtl/opponent_color_saliency.sv]
// Opponent color saliency: one BGR pixel in, one 8-bit saliency out. The
// block takes one pixel per clock unless an output stall has backed up to
// the first stage. Each result passes the prep register, the divider stage
// registers and the max register before it is presented. The depth is set by
// the division diff*255/level, done by a restoring divider of four stages
// that retire two quotient bits each, one divider per color category, with
// one stage before it for levels and tests and one after for the maximum.
// A stall on the output backs up stage by stage; empty stages still fill.
// Configuration writes are always taken and should only be issued while
// no pixel is in flight. Depends on ocs_pkg, ocs_if and the ocs_* stages.
module opponent_color_saliency
    import ocs_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    ocs_pixel_if.sink     pixel,
    ocs_result_if.source  result,
    ocs_cfg_if.sink       cfg
);

    cfg_t                   cfg_reg;
    logic [NUM_STAGES-1:0]  valid_reg;
    logic [NUM_STAGES:0]    adv;
    lane_t [NUM_CAT-1:0]    prep_lanes;
    lane_t [NUM_CAT-1:0]    div_lanes [DIV_STAGES+1];

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cat_enable     <= RST_CAT_ENABLE;
            cfg_reg.diff_threshold <= RST_DIFF_THRESHOLD;
            cfg_reg.level_floor    <= RST_LEVEL_FLOOR;
        end
        else if (cfg.valid)
        begin
            case (reg_index_t'(cfg.index))
                REG_CAT_ENABLE:     cfg_reg.cat_enable     <= cfg.data[NUM_CAT-1:0];
                REG_DIFF_THRESHOLD: cfg_reg.diff_threshold <= cfg.data[PIX_W-1:0];
                REG_LEVEL_FLOOR:    cfg_reg.level_floor    <= cfg.data[PIX_W-1:0];
                default:            ;
            endcase
        end
    end

    // a stage loads when it is empty or its successor loads
    always_comb
    begin
        adv[NUM_STAGES] = result.ready;
        for (int k = NUM_STAGES - 1; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    assign pixel.ready = adv[0];

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                valid_reg[0] <= pixel.valid;
            end
            for (int k = 1; k < NUM_STAGES; k++)
            begin
                if (adv[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // datapath
    ocs_prep u_prep (
        .clk   (clk),
        .load  (adv[0]),
        .blue  (pixel.blue),
        .green (pixel.green),
        .red   (pixel.red),
        .cfg   (cfg_reg),
        .lanes (prep_lanes)
    );

    assign div_lanes[0] = prep_lanes;

    for (genvar d = 0; d < DIV_STAGES; d++)
    begin : g_div
        ocs_div_stage u_div (
            .clk  (clk),
            .load (adv[d+1]),
            .din  (div_lanes[d]),
            .dout (div_lanes[d+1])
        );
    end

    ocs_max u_max (
        .clk      (clk),
        .load     (adv[NUM_STAGES-1]),
        .lanes    (div_lanes[DIV_STAGES]),
        .saliency (result.saliency)
    );

    assign result.valid = valid_reg[NUM_STAGES-1];

endmodule

[rtl/ocs_checker.sv]
// Port-level checks for opponent_color_saliency, attached by bind.
// Depends on ocs_pkg; watches the top-level channels only.
module ocs_checker
    import ocs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [PIX_W-1:0]      saliency,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [FLIGHT_W-1:0] flight_reg;
    logic [FLIGHT_W-1:0] flight_next;
    logic [NUM_CAT-1:0]  enable_reg;
    logic                in_xfer;
    logic                out_xfer;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;

    // items accepted but not yet delivered
    always_comb
    begin
        flight_next = flight_reg;
        if (in_xfer && !out_xfer)
        begin
            flight_next = flight_reg + 1'b1;
        end
        else if (!in_xfer && out_xfer)
        begin
            flight_next = flight_reg - 1'b1;
        end
    end

    // in-flight counter and shadow of the category enable register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flight_reg <= '0;
            enable_reg <= RST_CAT_ENABLE;
        end
        else
        begin
            flight_reg <= flight_next;
            if (cfg_valid && cfg_ready && (reg_index_t'(cfg_index) == REG_CAT_ENABLE))
            begin
                enable_reg <= cfg_data[NUM_CAT-1:0];
            end
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(saliency))
        else $error("result dropped or changed while stalled");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> flight_reg != '0)
        else $error("result presented with no pixel in flight");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        flight_reg <= FLIGHT_W'(NUM_STAGES))
        else $error("more pixels in flight than pipeline stages");

    a_none_enabled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (enable_reg == '0) |-> saliency == '0)
        else $error("nonzero saliency with all categories disabled");

endmodule

bind opponent_color_saliency ocs_checker u_ocs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pixel.valid),
    .in_ready  (pixel.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .saliency  (result.saliency),
    .cfg_valid (cfg.valid),
    .cfg_ready (cfg.ready),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data)
);
